FILE: rtl/core/msto_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msto_pkg: shared types and constants
// slot table size, command codes, payload words and controller/datapath links
// ----------------------------------------------------------------------------
package msto_pkg;

	localparam int SLOTS       = 16;
	localparam int MAX_RESULTS = 16;
	localparam int SLOT_W      = (SLOTS > 1) ? $clog2(SLOTS) : 1;
	localparam int CNT_W       = $clog2(MAX_RESULTS + 1);

	typedef enum logic [1:0] {
		KIND_TICK  = 2'd0,
		KIND_SET   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_RESET = 2'd3
	} kind_t;

	typedef struct packed {
		logic [1:0]  kind;
		logic [3:0]  slot;
		logic [15:0] delay;
		logic        repeat_req;
	} in_word_t;

	typedef struct packed {
		logic        fired;
		logic [3:0]  fired_slot;
		logic        last;
		logic [15:0] now;
	} out_word_t;

	typedef enum logic [1:0] {
		ST_IDLE = 2'd0,
		ST_EXEC = 2'd1,
		ST_SCAN = 2'd2,
		ST_FIN  = 2'd3
	} state_t;

	// controller to datapath
	typedef struct packed {
		logic              load;
		logic              exec;
		logic              scan;
		logic              fin;
		logic [SLOT_W-1:0] idx;
	} dp_cmd_t;

	// datapath to controller
	typedef struct packed {
		logic is_tick;
		logic any_active;
	} dp_stat_t;

endpackage

FILE: rtl/core/msto_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msto_ctrl: sequencing controller
// takes a word, runs the command step, then walks the slots on an active tick
// ----------------------------------------------------------------------------
module msto_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  msto_pkg::dp_stat_t stat,
	output logic               busy,
	output msto_pkg::dp_cmd_t  cmd
);

	msto_pkg::state_t state_q, state_d;
	logic [msto_pkg::SLOT_W-1:0] idx_q, idx_d;
	logic idx_end;

	assign idx_end = (idx_q == msto_pkg::SLOT_W'(msto_pkg::SLOTS - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= msto_pkg::ST_IDLE;
			idx_q   <= '0;
		end else begin
			state_q <= state_d;
			idx_q   <= idx_d;
		end
	end

	always_comb begin
		state_d  = state_q;
		idx_d    = idx_q;
		busy     = 1'b1;
		cmd.load = 1'b0;
		cmd.exec = 1'b0;
		cmd.scan = 1'b0;
		cmd.fin  = 1'b0;
		cmd.idx  = idx_q;
		case (state_q)
			msto_pkg::ST_IDLE: begin
				busy = 1'b0;
				if (start) begin
					cmd.load = 1'b1;
					state_d  = msto_pkg::ST_EXEC;
				end
			end
			msto_pkg::ST_EXEC: begin
				cmd.exec = 1'b1;
				idx_d    = '0;
				if (stat.is_tick && stat.any_active)
					state_d = msto_pkg::ST_SCAN;
				else
					state_d = msto_pkg::ST_IDLE;
			end
			msto_pkg::ST_SCAN: begin
				cmd.scan = 1'b1;
				if (idx_end) begin
					state_d = msto_pkg::ST_FIN;
				end else begin
					idx_d = idx_q + 1'b1;
				end
			end
			msto_pkg::ST_FIN: begin
				cmd.fin = 1'b1;
				state_d = msto_pkg::ST_IDLE;
			end
			default: begin
				state_d = msto_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

FILE: rtl/core/msto_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// msto_dp: slot table and counter datapath
// slot register file, millisecond counter, deadline adder, pending fire and result
// ----------------------------------------------------------------------------
module msto_dp (
	input  logic                clk,
	input  logic                arst_n,
	input  msto_pkg::in_word_t  item,
	input  msto_pkg::dp_cmd_t   cmd,
	output msto_pkg::dp_stat_t  stat,
	output logic                strobe,
	output msto_pkg::out_word_t result
);

	msto_pkg::in_word_t cmd_q;

	logic [msto_pkg::SLOTS-1:0] active_q;
	logic [msto_pkg::SLOTS-1:0] reload_q;
	logic [15:0]                period_q   [msto_pkg::SLOTS];
	logic [15:0]                deadline_q [msto_pkg::SLOTS];
	logic [15:0]                tick_q;

	logic                        pend_valid_q;
	logic [msto_pkg::SLOT_W-1:0] pend_slot_q;
	logic [msto_pkg::CNT_W-1:0]  rep_cnt_q;
	logic                        strobe_q;
	msto_pkg::out_word_t         result_q;

	logic [msto_pkg::SLOT_W-1:0] addr;
	logic        slot_ok;
	logic        is_tick;
	logic        any_active;
	logic        rd_active;
	logic        rd_reload;
	logic [15:0] rd_period;
	logic [15:0] rd_deadline;
	logic [15:0] add_op;
	logic [15:0] sum;
	logic        hit;
	logic        room;

	// one read address: scan position or the addressed slot
	assign addr        = cmd.scan ? cmd.idx : msto_pkg::SLOT_W'(cmd_q.slot);
	assign slot_ok     = (int'(cmd_q.slot) < msto_pkg::SLOTS);
	assign is_tick     = (cmd_q.kind == msto_pkg::KIND_TICK);
	assign any_active  = |active_q;
	assign rd_active   = active_q[addr];
	assign rd_reload   = reload_q[addr];
	assign rd_period   = period_q[addr];
	assign rd_deadline = deadline_q[addr];

	// reset with zero delay falls back to the stored delay
	always_comb begin
		if (cmd.scan)
			add_op = rd_period;
		else if (cmd_q.kind == msto_pkg::KIND_RESET && cmd_q.delay == 16'd0)
			add_op = rd_period;
		else
			add_op = cmd_q.delay;
	end

	assign sum  = tick_q + add_op;
	assign hit  = rd_active && (rd_deadline == tick_q);
	assign room = (rep_cnt_q < msto_pkg::CNT_W'(msto_pkg::MAX_RESULTS));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q     <= '0;
			tick_q       <= '0;
			pend_valid_q <= 1'b0;
			rep_cnt_q    <= '0;
			strobe_q     <= 1'b0;
		end else begin
			strobe_q <= 1'b0;
			if (cmd.exec) begin
				if (is_tick) begin
					pend_valid_q <= 1'b0;
					rep_cnt_q    <= '0;
					if (any_active)
						tick_q <= tick_q + 16'd1;
					else
						strobe_q <= 1'b1;
				end else begin
					strobe_q <= 1'b1;
					if (slot_ok) begin
						case (cmd_q.kind)
							msto_pkg::KIND_SET:   active_q[addr] <= 1'b1;
							msto_pkg::KIND_RESET: active_q[addr] <= 1'b1;
							msto_pkg::KIND_CLEAR: active_q[addr] <= 1'b0;
							default: ;
						endcase
					end
				end
			end
			if (cmd.scan && hit) begin
				if (!rd_reload)
					active_q[addr] <= 1'b0;
				if (room) begin
					pend_valid_q <= 1'b1;
					rep_cnt_q    <= rep_cnt_q + 1'b1;
					if (pend_valid_q)
						strobe_q <= 1'b1;
				end
			end
			if (cmd.fin)
				strobe_q <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load)
			cmd_q <= item;
		if (cmd.exec && !is_tick && slot_ok) begin
			case (cmd_q.kind)
				msto_pkg::KIND_SET: begin
					period_q[addr]   <= cmd_q.delay;
					deadline_q[addr] <= sum;
					reload_q[addr]   <= cmd_q.repeat_req;
				end
				msto_pkg::KIND_RESET: deadline_q[addr] <= sum;
				default: ;
			endcase
		end
		if (cmd.exec) begin
			result_q.fired      <= 1'b0;
			result_q.fired_slot <= is_tick ? 4'd0 : cmd_q.slot;
			result_q.last       <= 1'b1;
			result_q.now        <= tick_q;
		end
		if (cmd.scan && hit) begin
			if (rd_reload)
				deadline_q[addr] <= sum;
			if (room) begin
				pend_slot_q         <= cmd.idx;
				result_q.fired      <= 1'b1;
				result_q.fired_slot <= 4'(pend_slot_q);
				result_q.last       <= 1'b0;
				result_q.now        <= tick_q;
			end
		end
		if (cmd.fin) begin
			result_q.fired      <= pend_valid_q;
			result_q.fired_slot <= pend_valid_q ? 4'(pend_slot_q) : 4'd0;
			result_q.last       <= 1'b1;
			result_q.now        <= tick_q;
		end
	end

	assign stat.is_tick    = is_tick;
	assign stat.any_active = any_active;
	assign strobe          = strobe_q;
	assign result          = result_q;

endmodule

FILE: rtl/core/multi_slot_timeout_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// multi_slot_timeout_engine: multi-slot timeout engine
// table of timeout slots with a shared millisecond counter; ticks fire slots
// ----------------------------------------------------------------------------
//
// channel   | handshake              | word
// ----------+------------------------+---------------------------------------
// command   | start high, busy low   | item   : kind, slot, delay, repeat_req
// result    | strobe, single cycle   | result : fired, fired_slot, last, now
//
// a set, clear or reset word holds busy through its command step only; its
// acknowledgement shows in the cycle after the command step, as does that
// of a tick with no armed slot; a tick with an armed slot holds busy through
// the slot walk and a final word step; the walk does one table read,
// compare and update per cycle through the single slot register file port
// fire words appear during the walk and the final one follows the final word step
// arst_n clears all active marks, the counter and the controller
// results are not held off: each word is valid for the strobe cycle only
//
module multi_slot_timeout_engine (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  msto_pkg::in_word_t  item,
	output logic                busy,
	output logic                strobe,
	output msto_pkg::out_word_t result
);

	msto_pkg::dp_cmd_t  dp_cmd;
	msto_pkg::dp_stat_t dp_stat;

	// sequencer: idle, command step, slot walk, final word
	msto_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (dp_stat),
		.busy   (busy),
		.cmd    (dp_cmd)
	);

	// slot table, counter and result register
	msto_dp u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.item   (item),
		.cmd    (dp_cmd),
		.stat   (dp_stat),
		.strobe (strobe),
		.result (result)
	);

	// an accepted word keeps the block busy in the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("accepted word did not make the block busy");

	// a word that is not the final one only comes out mid-walk
	a_nonlast_busy: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.last |-> busy)
		else $error("non-final result outside a slot walk");

	// acknowledgements always close their word
	a_ack_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !result.fired |-> result.last)
		else $error("acknowledgement without last");

	// an active tick in the command step always starts the slot walk
	a_walk_entry: assert property (@(posedge clk) disable iff (!arst_n)
		dp_cmd.exec && dp_stat.is_tick && dp_stat.any_active |=> dp_cmd.scan)
		else $error("active tick did not start a slot walk");

endmodule
